/* src/iohub_pkg.sv */
// Package for the I/O hub register block: address map, access kinds,
// fixed status values and DMA interrupt register masks. No dependencies.
package iohub_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned KIND_W = 2;

    // Access kinds carried in tuser
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAISE = 2'd2;

    // Register window (inclusive bounds)
    localparam logic [ADDR_W-1:0] WIN_LOW  = 32'h1F80_0000;
    localparam logic [ADDR_W-1:0] WIN_HIGH = 32'h1F80_2FFF;

    // Register addresses
    localparam logic [ADDR_W-1:0] ADDR_I_STAT  = 32'h1F80_1070;
    localparam logic [ADDR_W-1:0] ADDR_I_MASK  = 32'h1F80_1074;
    localparam logic [ADDR_W-1:0] ADDR_DPCR    = 32'h1F80_10F0;
    localparam logic [ADDR_W-1:0] ADDR_DICR    = 32'h1F80_10F4;
    localparam logic [ADDR_W-1:0] ADDR_TMR0    = 32'h1F80_1100;
    localparam logic [ADDR_W-1:0] ADDR_TMR1    = 32'h1F80_1110;
    localparam logic [ADDR_W-1:0] ADDR_TMR2    = 32'h1F80_1120;
    localparam logic [ADDR_W-1:0] ADDR_TMR3    = 32'h1F80_1130;
    localparam logic [ADDR_W-1:0] ADDR_SIO_ST  = 32'h1F80_1200;
    localparam logic [ADDR_W-1:0] ADDR_CH_ST   = 32'h1F80_1450;
    localparam logic [ADDR_W-1:0] ADDR_XFER_ST = 32'h1F80_1578;
    localparam logic [ADDR_W-1:0] ADDR_SEMA    = 32'h1F80_157C;
    localparam logic [ADDR_W-1:0] ADDR_DISC0   = 32'h1F80_1E00;
    localparam logic [ADDR_W-1:0] ADDR_DISC1   = 32'h1F80_1E80;

    // Fixed status values
    localparam logic [DATA_W-1:0] VAL_SIO_ST  = 32'h0000_0005;
    localparam logic [DATA_W-1:0] VAL_CH_ST   = 32'h1D00_0000;
    localparam logic [DATA_W-1:0] VAL_XFER_ST = 32'h0000_0001;
    localparam logic [DATA_W-1:0] VAL_DISC_ST = 32'h0000_0003;

    // DMA interrupt register write merge
    localparam logic [DATA_W-1:0] DICR_KEEP_MASK = 32'h7F00_0000;
    localparam logic [DATA_W-1:0] DICR_FORCE     = 32'h8000_0000;

    localparam int unsigned NUM_TIMERS = 4;
    localparam int unsigned TMR_IDX_W  = 2;

endpackage

/* src/io_hub_register_block_unit.sv */
// Top level of the I/O hub register block: input register, decode and
// register file update, result register. Depends on iohub_pkg.
//
// Usage:
//   Slave stream (s_axis) carries one bus access per transaction:
//     tuser = kind (0 read, 1 write, 2 raise interrupt status bits),
//     tdata = address in bits [31:0], write data in bits [63:32].
//   Master stream (m_axis) returns exactly one result per access, in order:
//     tdata = read data, tuser[0] = handled (read or write whose address fell in the window).
// Flow: the access lands in the input register at the accepting edge and
//   moves into the result register, raising o_m_axis_tvalid, once the
//   result register is free or being taken.
//   Throughput: one transaction per cycle while i_m_axis_tready is not held
//   low, set by the single decode/update stage between the two registers;
//   register file state is updated as an access leaves the input register,
//   so back-to-back accesses see each other's effects in order.
// Reset (i_rst_n low, synchronous): both pipeline registers empty, every
//   register and timer counter cleared to zero.
// Stall: while i_m_axis_tready is low the result register holds; the input
//   register still takes one more transaction, after which o_s_axis_tready
//   drops until the result is taken. No transaction is dropped or repeated.
module io_hub_register_block_unit
    import iohub_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [63:0]          i_s_axis_tdata,   // [31:0] address, [63:32] write_data
    input  logic [KIND_W-1:0]    i_s_axis_tuser,   // [1:0] kind
    // master side
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [DATA_W-1:0]    o_m_axis_tdata,   // [31:0] read_data
    output logic [0:0]           o_m_axis_tuser    // [0] handled
);

    // input register
    logic              r_in_valid;
    logic [KIND_W-1:0] r_in_kind;
    logic [ADDR_W-1:0] r_in_addr;
    logic [DATA_W-1:0] r_in_wdata;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rdata;
    logic              r_out_hit;

    // register file
    logic [DATA_W-1:0] r_irq_stat, n_irq_stat;
    logic [DATA_W-1:0] r_irq_mask, n_irq_mask;
    logic [DATA_W-1:0] r_dpcr,     n_dpcr;
    logic [DATA_W-1:0] r_dicr,     n_dicr;
    logic [DATA_W-1:0] r_sema,     n_sema;
    logic [DATA_W-1:0] r_timer [NUM_TIMERS];
    logic [DATA_W-1:0] n_timer_val;
    logic              n_timer_we;

    logic [DATA_W-1:0] n_rdata;
    logic              n_hit;

    logic              in_fire;
    logic              out_free;
    logic              stage_adv;
    logic              in_win;
    logic [TMR_IDX_W-1:0] tmr_idx;
    logic [DATA_W-1:0] tmr_inc;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign stage_adv       = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_rdata;
    assign o_m_axis_tuser[0] = r_out_hit;

    assign in_win  = (r_in_addr >= WIN_LOW) && (r_in_addr <= WIN_HIGH);
    // timer select comes from address bits [5:4] (0x...1100 + 0x10*n)
    assign tmr_idx = r_in_addr[5:4];
    assign tmr_inc = r_timer[tmr_idx] + DATA_W'(1);

    // decode and next-state for the access in the input register
    always_comb begin
        n_irq_stat  = r_irq_stat;
        n_irq_mask  = r_irq_mask;
        n_dpcr      = r_dpcr;
        n_dicr      = r_dicr;
        n_sema      = r_sema;
        n_timer_val = tmr_inc;
        n_timer_we  = 1'b0;
        n_rdata     = '0;
        n_hit       = 1'b0;

        if (r_in_kind == KIND_RAISE) begin
            n_irq_stat = r_irq_stat | r_in_wdata;
            n_rdata    = n_irq_stat;
        end else if (r_in_kind == KIND_READ && in_win) begin
            n_hit = 1'b1;
            unique case (r_in_addr)
                ADDR_I_STAT:  n_rdata = r_irq_stat;
                ADDR_I_MASK:  n_rdata = r_irq_mask;
                ADDR_DPCR:    n_rdata = r_dpcr;
                ADDR_DICR:    n_rdata = r_dicr;
                ADDR_TMR0, ADDR_TMR1, ADDR_TMR2, ADDR_TMR3: begin
                    n_timer_we = 1'b1;
                    n_rdata    = tmr_inc;
                end
                ADDR_SIO_ST:  n_rdata = VAL_SIO_ST;
                ADDR_CH_ST:   n_rdata = VAL_CH_ST;
                ADDR_XFER_ST: n_rdata = VAL_XFER_ST;
                ADDR_SEMA:    n_rdata = r_sema;
                ADDR_DISC0, ADDR_DISC1: n_rdata = VAL_DISC_ST;
                default:      n_rdata = '0;
            endcase
        end else if (r_in_kind == KIND_WRITE && in_win) begin
            n_hit = 1'b1;
            unique case (r_in_addr)
                ADDR_I_STAT: n_irq_stat = r_irq_stat & ~r_in_wdata;  // write-one-to-clear
                ADDR_I_MASK: n_irq_mask = r_in_wdata;
                ADDR_DPCR:   n_dpcr     = r_in_wdata;
                ADDR_DICR:   n_dicr     = (r_dicr & ~r_in_wdata)
                                        | (r_in_wdata & DICR_KEEP_MASK) | DICR_FORCE;
                ADDR_SEMA:   n_sema     = r_in_wdata;
                default:     ;
            endcase
        end
        // reserved kind: no effect, zero result
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (stage_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_kind  <= i_s_axis_tuser;
            r_in_addr  <= i_s_axis_tdata[31:0];
            r_in_wdata <= i_s_axis_tdata[63:32];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv) begin
            r_out_rdata <= n_rdata;
            r_out_hit   <= n_hit;
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_stat <= '0;
            r_irq_mask <= '0;
            r_dpcr     <= '0;
            r_dicr     <= '0;
            r_sema     <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_timer[i] <= '0;
            end
        end else if (stage_adv) begin
            r_irq_stat <= n_irq_stat;
            r_irq_mask <= n_irq_mask;
            r_dpcr     <= n_dpcr;
            r_dicr     <= n_dicr;
            r_sema     <= n_sema;
            if (n_timer_we) begin
                r_timer[tmr_idx] <= n_timer_val;
            end
        end
    end

    // checks
    a_dicr_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && r_in_kind == KIND_WRITE && r_in_addr == ADDR_DICR |=> r_dicr[31])
        else $error("DMA interrupt register write did not force bit 31");

    a_raise_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && r_in_kind == KIND_RAISE
        |=> ((r_irq_stat & $past(r_in_wdata)) == $past(r_in_wdata)) && r_out_rdata == r_irq_stat)
        else $error("raise did not set interrupt status bits");

    a_timer0_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && r_in_kind == KIND_READ && r_in_addr == ADDR_TMR0
        |=> r_timer[0] == $past(r_timer[0]) + DATA_W'(1))
        else $error("timer 0 did not count on read");

    a_outside_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && !in_win && r_in_kind != KIND_RAISE
        |=> $stable(r_irq_stat) && $stable(r_irq_mask) && $stable(r_dicr) && !r_out_hit)
        else $error("access outside window changed state or was marked handled");

    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv |=> r_out_valid)
        else $error("result register lost a transaction");

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for io_hub_register_block_unit: stream driver, stream
// monitor and an in-bench register map predictor. Depends on iohub_pkg.
`timescale 1ns / 100ps

module testbench;
    import iohub_pkg::*;

    // Kind 3 is not a defined access; the block must ignore it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned RANDOM_ACCESSES = 600;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } hub_access_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              handled;
    } hub_result_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_valid = 1'b0;
    logic [63:0]          s_data  = '0;     // [31:0] address, [63:32] write_data
    logic [KIND_W-1:0]    s_user  = '0;     // [1:0] kind
    logic                 m_ready = 1'b0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [DATA_W-1:0]    o_m_axis_tdata;   // [31:0] read_data
    logic [0:0]           o_m_axis_tuser;   // [0] handled

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Single reset pulse at start of run
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    io_hub_register_block_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Predicted register file
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] irq_status   = '0;
    logic [DATA_W-1:0] irq_mask     = '0;
    logic [DATA_W-1:0] dma_prio     = '0;
    logic [DATA_W-1:0] dma_irq_ctrl = '0;
    logic [DATA_W-1:0] sema         = '0;
    logic [DATA_W-1:0] tmr_count [NUM_TIMERS];

    initial begin
        for (int n = 0; n < NUM_TIMERS; n++) tmr_count[n] = '0;
    end

    hub_access_t access_queue [$];      // accesses not yet offered
    hub_result_t pending_results [$];   // predicted results, oldest first

    int unsigned errors     = 0;
    int unsigned n_sent     = 0;
    int unsigned n_checked  = 0;
    int unsigned n_reads    = 0;
    int unsigned n_writes   = 0;
    int unsigned n_raises   = 0;
    int unsigned n_unused   = 0;
    int unsigned n_outside  = 0;

    // Applies one access to the predicted registers and returns its result.
    // Timer reads count up before returning the value; kind 2 ignores the
    // address and always reports not handled.
    function automatic hub_result_t access_result(hub_access_t acc);
        hub_result_t          res;
        logic                 in_win;
        logic [TMR_IDX_W-1:0] t;
        res    = '0;
        in_win = (acc.addr >= WIN_LOW) && (acc.addr <= WIN_HIGH);
        t      = acc.addr[5:4];
        if (acc.kind == KIND_RAISE) begin
            irq_status = irq_status | acc.wdata;
            res.rdata  = irq_status;
        end else if (acc.kind == KIND_READ && in_win) begin
            res.handled = 1'b1;
            case (acc.addr)
                ADDR_I_STAT:  res.rdata = irq_status;
                ADDR_I_MASK:  res.rdata = irq_mask;
                ADDR_DPCR:    res.rdata = dma_prio;
                ADDR_DICR:    res.rdata = dma_irq_ctrl;
                ADDR_TMR0, ADDR_TMR1, ADDR_TMR2, ADDR_TMR3: begin
                    tmr_count[t] = tmr_count[t] + 1'b1;
                    res.rdata    = tmr_count[t];
                end
                ADDR_SIO_ST:  res.rdata = VAL_SIO_ST;
                ADDR_CH_ST:   res.rdata = VAL_CH_ST;
                ADDR_XFER_ST: res.rdata = VAL_XFER_ST;
                ADDR_SEMA:    res.rdata = sema;
                ADDR_DISC0, ADDR_DISC1: res.rdata = VAL_DISC_ST;
                default:      res.rdata = '0;
            endcase
        end else if (acc.kind == KIND_WRITE && in_win) begin
            res.handled = 1'b1;
            case (acc.addr)
                ADDR_I_STAT: irq_status = irq_status & ~acc.wdata;
                ADDR_I_MASK: irq_mask   = acc.wdata;
                ADDR_DPCR:   dma_prio   = acc.wdata;
                ADDR_DICR:   dma_irq_ctrl = (dma_irq_ctrl & ~acc.wdata)
                                          | (acc.wdata & DICR_KEEP_MASK) | DICR_FORCE;
                ADDR_SEMA:   sema       = acc.wdata;
                default: ;
            endcase
        end
        return res;
    endfunction

    // Idle length: mostly none or short, a few long; every fourth stretch of
    // 80 transactions runs with no idling at all.
    function automatic int unsigned pick_idle(int unsigned count);
        int unsigned r;
        if ((count / 80) % 4 == 3) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(2, 1);
        if (r < 97) return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    // Decoded addresses, for biased random stimulus
    function automatic logic [ADDR_W-1:0] reg_addr(int unsigned idx);
        case (idx)
            0:  return ADDR_I_STAT;
            1:  return ADDR_I_MASK;
            2:  return ADDR_DPCR;
            3:  return ADDR_DICR;
            4:  return ADDR_TMR0;
            5:  return ADDR_TMR1;
            6:  return ADDR_TMR2;
            7:  return ADDR_TMR3;
            8:  return ADDR_SIO_ST;
            9:  return ADDR_CH_ST;
            10: return ADDR_XFER_ST;
            11: return ADDR_SEMA;
            12: return ADDR_DISC0;
            default: return ADDR_DISC1;
        endcase
    endfunction

    task automatic push_access(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] wdata);
        hub_access_t acc;
        acc.kind  = kind;
        acc.addr  = addr;
        acc.wdata = wdata;
        access_queue.push_back(acc);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued accesses, predicts each one as its transaction
    // completes, then idles for a random gap.
    // ------------------------------------------------------------------
    hub_access_t cur_acc;
    int unsigned src_gap = 0;

    always @(posedge i_clk) begin : drive_proc
        logic took;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            took = s_valid && o_s_axis_tready;
            if (took) begin
                pending_results.push_back(access_result(cur_acc));
                n_sent++;
                case (cur_acc.kind)
                    KIND_READ:  n_reads++;
                    KIND_WRITE: n_writes++;
                    KIND_RAISE: n_raises++;
                    default:    n_unused++;
                endcase
                if (cur_acc.kind != KIND_RAISE &&
                    (cur_acc.addr < WIN_LOW || cur_acc.addr > WIN_HIGH))
                    n_outside++;
                src_gap = pick_idle(n_sent);
            end
            if (s_valid && !took) begin
                // hold the offered transaction until accepted
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (access_queue.size() > 0) begin
                cur_acc = access_queue.pop_front();
                s_data  <= {cur_acc.wdata, cur_acc.addr};
                s_user  <= cur_acc.kind;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result transaction with the oldest prediction
    // and stalls the result stream at random.
    // ------------------------------------------------------------------
    int unsigned sink_stall = 0;

    always @(posedge i_clk) begin : monitor_proc
        hub_result_t want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: read_data %h handled %b",
                           o_m_axis_tdata, o_m_axis_tuser[0]);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (o_m_axis_tdata !== want.rdata) begin
                        $error("read_data: expected %h, got %h", want.rdata, o_m_axis_tdata);
                        errors++;
                    end
                    if (o_m_axis_tuser[0] !== want.handled) begin
                        $error("handled: expected %b, got %b", want.handled,
                               o_m_axis_tuser[0]);
                        errors++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(99) < 30) sink_stall = pick_idle(n_checked);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int unsigned cycle_cnt = 0;

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [KIND_W-1:0] k;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] w;
        int unsigned       r;
        int unsigned       n_total;

        // Directed: status set/clear, the plain registers written and read back,
        // DMA interrupt merge, timers, fixed status values, window edges,
        // unaligned address and the undefined kind.
        push_access(KIND_RAISE,  32'h0000_0000, 32'hFFFF_FFFF);
        push_access(KIND_READ,   ADDR_I_STAT,   32'h0);
        push_access(KIND_WRITE,  ADDR_I_STAT,   32'hA5A5_A5A5);
        push_access(KIND_READ,   ADDR_I_STAT,   32'h0);
        push_access(KIND_WRITE,  ADDR_I_MASK,   32'hFFFF_FFFF);
        push_access(KIND_READ,   ADDR_I_MASK,   32'h0);
        push_access(KIND_WRITE,  ADDR_DPCR,     32'hFFFF_FFFF);
        push_access(KIND_READ,   ADDR_DPCR,     32'h0);
        push_access(KIND_WRITE,  ADDR_DICR,     32'h0000_0000);
        push_access(KIND_READ,   ADDR_DICR,     32'h0);
        push_access(KIND_WRITE,  ADDR_DICR,     32'hFFFF_FFFF);
        push_access(KIND_READ,   ADDR_DICR,     32'h0);
        push_access(KIND_WRITE,  ADDR_SEMA,     32'hDEAD_BEEF);
        push_access(KIND_READ,   ADDR_SEMA,     32'h0);
        push_access(KIND_READ,   ADDR_TMR0,     32'h0);
        push_access(KIND_READ,   ADDR_TMR3,     32'h0);
        push_access(KIND_READ,   ADDR_SIO_ST,   32'h0);
        push_access(KIND_READ,   ADDR_CH_ST,    32'h0);
        push_access(KIND_READ,   ADDR_XFER_ST,  32'h0);
        push_access(KIND_READ,   ADDR_DISC0,    32'h0);
        push_access(KIND_READ,   ADDR_DISC1,    32'h0);
        push_access(KIND_READ,   WIN_HIGH,      32'h0);
        push_access(KIND_READ,   WIN_LOW - 1,   32'h0);
        push_access(KIND_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_access(KIND_READ,   ADDR_I_STAT + 2, 32'h0);
        push_access(KIND_UNUSED, ADDR_I_MASK,   32'h0000_0000);

        // Random: mostly decoded registers, some stray window addresses,
        // window edges and fully random addresses.
        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            r = $urandom_range(99);
            if (r < 45)      k = KIND_READ;
            else if (r < 80) k = KIND_WRITE;
            else if (r < 95) k = KIND_RAISE;
            else             k = KIND_UNUSED;

            r = $urandom_range(99);
            if (r < 65)      a = reg_addr($urandom_range(13));
            else if (r < 80) a = WIN_LOW + $urandom_range(WIN_HIGH - WIN_LOW);
            else if (r < 85) begin
                case ($urandom_range(3))
                    0: a = WIN_LOW;
                    1: a = WIN_HIGH;
                    2: a = WIN_LOW - 1;
                    default: a = WIN_HIGH + 1;
                endcase
            end else         a = $urandom();

            r = $urandom_range(99);
            if (r < 10)      w = 32'hFFFF_FFFF;
            else if (r < 15) w = 32'h0000_0000;
            else if (k == KIND_RAISE) w = $urandom() & $urandom();  // sparse bits
            else             w = $urandom();

            push_access(k, a, w);
        end
        n_total = access_queue.size();

        // every queued access must come back as a compared result
        @(posedge i_clk iff i_rst_n);
        while (n_checked < n_total)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            errors++;
        end

        $display("Ran %0d accesses: %0d reads, %0d writes, %0d raises, %0d undefined kind,",
                 n_sent, n_reads, n_writes, n_raises, n_unused);
        $display("%0d outside the window; %0d results compared, %0d mismatches.",
                 n_outside, n_checked, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
